@@ src/fbrmq_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the message queue.
package fbrmq_pkg;

  // Ring geometry and framing.
  localparam int QUEUE_BYTES       = 1024;
  localparam int MAX_MESSAGE_BYTES = 64;
  localparam int ID_BYTES          = 4;
  localparam int HDR_BYTES         = ID_BYTES + 2;
  localparam int MAX_PAYLOAD       = MAX_MESSAGE_BYTES - HDR_BYTES;

  // Field widths of the item channels.
  localparam int ACTION_W = 2;
  localparam int ID_W     = 32;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;
  localparam int REPORT_W = 11;

  // Internal widths.
  localparam int PTR_W  = $clog2(QUEUE_BYTES);
  localparam int CNT_W  = $clog2(QUEUE_BYTES + 1);
  localparam int SIZE_W = 7;
  localparam int HIDX_W = $clog2(HDR_BYTES);
  localparam int LCMP_W = (CNT_W > 16) ? CNT_W : 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SEND_HDR  = 2'd0,
    ACT_SEND_BYTE = 2'd1,
    ACT_RECEIVE   = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_ROOM   = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_BYTE   = 2'd2
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              latch;
    logic              wr_hdr;
    logic [HIDX_W-1:0] hdr_idx;
    logic              hdr_done;
    logic              wr_pay;
    logic              rd_hdr;
    logic              rx_len;
    logic              emit_ack;
    status_e           ack_status;
    logic              emit_head;
    logic              emit_byte;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    owed_zero;
    logic    too_large;
    logic    no_room;
    logic    pending_zero;
    logic    len_zero;
    logic    rem_one;
    logic    out_free;
  } stat_t;

endpackage

@@ src/fbrmq_in_if.sv @@
// Input item channel: valid/ready handshake with the request fields.
interface fbrmq_in_if;
  import fbrmq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     message_id;
  logic [LEN_W-1:0]    data_len;
  logic [BYTE_W-1:0]   data_byte;

  modport source (output valid, action, message_id, data_len, data_byte, input ready);
  modport sink   (input valid, action, message_id, data_len, data_byte, output ready);
endinterface

@@ src/fbrmq_out_if.sv @@
// Result item channel: valid/ready handshake with the result fields.
interface fbrmq_out_if;
  import fbrmq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     out_message_id;
  logic [LEN_W-1:0]    out_data_len;
  logic [BYTE_W-1:0]   out_byte;
  logic                last;
  logic [REPORT_W-1:0] pending_count;
  logic [REPORT_W-1:0] peak_pending;
  logic [REPORT_W-1:0] fill_bytes;
  logic [REPORT_W-1:0] peak_fill;

  modport source (output valid, status, kind, out_message_id, out_data_len, out_byte, last,
                  pending_count, peak_pending, fill_bytes, peak_fill, input ready);
  modport sink   (input valid, status, kind, out_message_id, out_data_len, out_byte, last,
                  pending_count, peak_pending, fill_bytes, peak_fill, output ready);
endinterface

@@ src/fbrmq_ctrl.sv @@
// Controller state machine: sequences header writes, header reads and result runs.
module fbrmq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fbrmq_pkg::stat_t stat_i,
  output fbrmq_pkg::cmd_t  cmd_o
);
  import fbrmq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECIDE  = 9'b000000010,
    S_TX_HDR  = 9'b000000100,
    S_ACK     = 9'b000001000,
    S_RX_HDR  = 9'b000010000,
    S_RX_CAP  = 9'b000100000,
    S_RX_LEN  = 9'b001000000,
    S_RX_HEAD = 9'b010000000,
    S_RX_PAY  = 9'b100000000
  } state_e;

  localparam logic [HIDX_W-1:0] HdrLastIdx = HIDX_W'(HDR_BYTES - 1);

  state_e            state_q, state_d;
  logic [HIDX_W-1:0] idx_q, idx_d;
  status_e           ack_status_q, ack_status_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    ack_status_d = ack_status_q;
    cmd_o        = '0;
    cmd_o.hdr_idx    = idx_q;
    cmd_o.ack_status = ack_status_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end

      S_DECIDE: begin
        idx_d   = '0;
        state_d = S_ACK;
        case (stat_i.action)
          ACT_SEND_HDR: begin
            if (!stat_i.owed_zero) begin
              ack_status_d = ST_IGNORED;
            end else if (stat_i.too_large) begin
              ack_status_d = ST_TOO_LARGE;
            end else if (stat_i.no_room) begin
              ack_status_d = ST_NO_ROOM;
            end else begin
              ack_status_d = ST_OK;
              state_d      = S_TX_HDR;
            end
          end
          ACT_SEND_BYTE: begin
            if (stat_i.owed_zero) begin
              ack_status_d = ST_IGNORED;
            end else begin
              cmd_o.wr_pay = 1'b1;
              ack_status_d = ST_OK;
            end
          end
          ACT_RECEIVE: begin
            if (stat_i.pending_zero) begin
              ack_status_d = ST_EMPTY;
            end else begin
              state_d = S_RX_HDR;
            end
          end
          default: begin
            ack_status_d = ST_IGNORED;
          end
        endcase
      end

      // One header byte goes into the ring each cycle.
      S_TX_HDR: begin
        cmd_o.wr_hdr = 1'b1;
        if (idx_q == HdrLastIdx) begin
          cmd_o.hdr_done = 1'b1;
          state_d        = S_ACK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_ACK: begin
        if (stat_i.out_free) begin
          cmd_o.emit_ack = 1'b1;
          state_d        = S_IDLE;
        end
      end

      // One header byte is read from the ring each cycle.
      S_RX_HDR: begin
        cmd_o.rd_hdr = 1'b1;
        if (idx_q == HdrLastIdx) begin
          state_d = S_RX_CAP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_RX_CAP: begin
        state_d = S_RX_LEN;
      end

      S_RX_LEN: begin
        cmd_o.rx_len = 1'b1;
        state_d      = S_RX_HEAD;
      end

      S_RX_HEAD: begin
        if (stat_i.out_free) begin
          cmd_o.emit_head = 1'b1;
          state_d         = stat_i.len_zero ? S_IDLE : S_RX_PAY;
        end
      end

      S_RX_PAY: begin
        if (stat_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          if (stat_i.rem_one) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      ack_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      ack_status_q <= ack_status_d;
    end
  end

endmodule

@@ src/fbrmq_dp.sv @@
// Datapath: ring memory, pointers, counters, header assembly and the result register.
module fbrmq_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fbrmq_pkg::cmd_t                 cmd_i,
  output fbrmq_pkg::stat_t                stat_o,
  input  logic [fbrmq_pkg::ACTION_W-1:0]  action_i,
  input  logic [fbrmq_pkg::ID_W-1:0]      message_id_i,
  input  logic [fbrmq_pkg::LEN_W-1:0]     data_len_i,
  input  logic [fbrmq_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fbrmq_pkg::STATUS_W-1:0]  status_o,
  output logic [fbrmq_pkg::KIND_W-1:0]    kind_o,
  output logic [fbrmq_pkg::ID_W-1:0]      out_message_id_o,
  output logic [fbrmq_pkg::LEN_W-1:0]     out_data_len_o,
  output logic [fbrmq_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                            last_o,
  output logic [fbrmq_pkg::REPORT_W-1:0]  pending_count_o,
  output logic [fbrmq_pkg::REPORT_W-1:0]  peak_pending_o,
  output logic [fbrmq_pkg::REPORT_W-1:0]  fill_bytes_o,
  output logic [fbrmq_pkg::REPORT_W-1:0]  peak_fill_o
);
  import fbrmq_pkg::*;

  localparam int SR_W = HDR_BYTES * BYTE_W;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_BYTES - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Latched request fields.
  action_e           action_q;
  logic [ID_W-1:0]   id_q;
  logic [LEN_W-1:0]  dlen_q;
  logic [BYTE_W-1:0] data_q;

  // Queue state.
  logic [BYTE_W-1:0] ring_mem [QUEUE_BYTES];
  logic [PTR_W-1:0]  wp_q, rp_q;
  logic [CNT_W-1:0]  pending_q, peak_pending_q, held_q, peak_held_q;
  logic [LEN_W-1:0]  owed_q;
  logic [SIZE_W-1:0] open_size_q;

  // Receive side.
  logic [BYTE_W-1:0] rdata_q;
  logic              cap_q;
  logic [SR_W-1:0]   hdr_sr_q;
  logic [LEN_W-1:0]  len_q, rem_q;

  // Result register.
  logic                out_valid_q;
  status_e             status_q;
  kind_e               kind_q;
  logic [ID_W-1:0]     out_id_q;
  logic [LEN_W-1:0]    out_len_q;
  logic [BYTE_W-1:0]   out_byte_q;
  logic                last_q;
  logic [REPORT_W-1:0] rep_pending_q, rep_peak_pending_q, rep_fill_q, rep_peak_fill_q;

  logic [SIZE_W-1:0] size;
  logic [CNT_W-1:0]  free_bytes;
  logic [BYTE_W-1:0] hdr_byte;
  logic              wr_en;
  logic [BYTE_W-1:0] wdata;
  logic              commit;
  logic [SIZE_W-1:0] commit_size;
  logic [CNT_W-1:0]  held_commit, pending_commit;
  logic [LCMP_W-1:0] len_stored, avail, len_a, len_c;
  logic [LEN_W-1:0]  len_calc;
  logic [CNT_W-1:0]  consumed, held_rx;
  logic              out_free, rd_en;

  // Admission checks on the latched header.
  assign size       = SIZE_W'(HDR_BYTES) + SIZE_W'(dlen_q);
  assign free_bytes = CNT_W'(QUEUE_BYTES) - held_q;
  assign out_free   = !out_valid_q || out_ready_i;

  assign stat_o.action       = action_q;
  assign stat_o.owed_zero    = (owed_q == '0);
  assign stat_o.too_large    = (size > SIZE_W'(MAX_MESSAGE_BYTES));
  assign stat_o.no_room      = (free_bytes < CNT_W'(size));
  assign stat_o.pending_zero = (pending_q == '0);
  assign stat_o.len_zero     = (len_q == '0);
  assign stat_o.rem_one      = (rem_q == LEN_W'(1));
  assign stat_o.out_free     = out_free;

  // Header byte for the current index: identifier bytes, then the length low and high bytes.
  always_comb begin
    hdr_byte = '0;
    if (cmd_i.hdr_idx < HIDX_W'(ID_BYTES)) begin
      hdr_byte = id_q[BYTE_W*cmd_i.hdr_idx +: BYTE_W];
    end else if (cmd_i.hdr_idx == HIDX_W'(ID_BYTES)) begin
      hdr_byte = BYTE_W'(dlen_q);
    end
  end

  assign wr_en = cmd_i.wr_hdr || cmd_i.wr_pay;
  assign wdata = cmd_i.wr_pay ? data_q : hdr_byte;

  // Commit of the open message on its last byte, or at once for an empty payload.
  assign commit         = (cmd_i.hdr_done && (dlen_q == '0)) ||
                          (cmd_i.wr_pay && (owed_q == LEN_W'(1)));
  assign commit_size    = cmd_i.hdr_done ? size : open_size_q;
  assign held_commit    = held_q + CNT_W'(commit_size);
  assign pending_commit = pending_q + 1'b1;

  // Received length, clamped to the bytes held and to the payload limit.
  assign len_stored = LCMP_W'(hdr_sr_q[SR_W-1 -: 16]);
  assign avail      = (held_q > CNT_W'(HDR_BYTES)) ? LCMP_W'(held_q - CNT_W'(HDR_BYTES)) : '0;
  assign len_a      = (len_stored > avail) ? avail : len_stored;
  assign len_c      = (len_a > LCMP_W'(MAX_PAYLOAD)) ? LCMP_W'(MAX_PAYLOAD) : len_a;
  assign len_calc   = len_c[LEN_W-1:0];
  assign consumed   = CNT_W'(HDR_BYTES) + CNT_W'(len_calc);
  assign held_rx    = (held_q > consumed) ? (held_q - consumed) : '0;

  // A ring read is issued for each header byte and ahead of each payload result.
  assign rd_en = cmd_i.rd_hdr || (cmd_i.rx_len && (len_calc != '0)) ||
                 (cmd_i.emit_byte && (rem_q != LEN_W'(1)));

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_e'(action_i);
      id_q     <= message_id_i;
      dlen_q   <= data_len_i;
      data_q   <= data_byte_i;
    end
  end

  // Ring memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wp_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= ring_mem[rp_q];
    end
  end

  // Pointers, counts and high-water marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q           <= '0;
      rp_q           <= '0;
      pending_q      <= '0;
      peak_pending_q <= '0;
      held_q         <= '0;
      peak_held_q    <= '0;
      owed_q         <= '0;
      open_size_q    <= '0;
      cap_q          <= 1'b0;
    end else begin
      cap_q <= cmd_i.rd_hdr;
      if (wr_en) begin
        wp_q <= ptr_next(wp_q);
      end
      if (rd_en) begin
        rp_q <= ptr_next(rp_q);
      end
      // A commit closes the open message; otherwise a header opens one and a byte counts down.
      if (commit) begin
        open_size_q <= '0;
        owed_q      <= '0;
        held_q      <= held_commit;
        pending_q   <= pending_commit;
        if (held_commit > peak_held_q) begin
          peak_held_q <= held_commit;
        end
        if (pending_commit > peak_pending_q) begin
          peak_pending_q <= pending_commit;
        end
      end else if (cmd_i.hdr_done) begin
        open_size_q <= size;
        owed_q      <= dlen_q;
      end else if (cmd_i.wr_pay) begin
        owed_q <= owed_q - 1'b1;
      end
      if (cmd_i.rx_len) begin
        held_q    <= held_rx;
        pending_q <= pending_q - 1'b1;
      end
    end
  end

  // Header assembly, least significant byte first, and the payload run length.
  always_ff @(posedge clk_i) begin
    if (cap_q) begin
      hdr_sr_q <= {rdata_q, hdr_sr_q[SR_W-1:BYTE_W]};
    end
    if (cmd_i.rx_len) begin
      len_q <= len_calc;
      rem_q <= len_calc;
    end else if (cmd_i.emit_byte) begin
      rem_q <= rem_q - 1'b1;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ack || cmd_i.emit_head || cmd_i.emit_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ack || cmd_i.emit_head || cmd_i.emit_byte) begin
      status_q           <= cmd_i.emit_ack ? cmd_i.ack_status : ST_OK;
      kind_q             <= cmd_i.emit_head ? KIND_HEADER :
                            (cmd_i.emit_byte ? KIND_BYTE : KIND_ACK);
      out_id_q           <= cmd_i.emit_head ? ID_W'(hdr_sr_q[ID_BYTES*BYTE_W-1:0]) : '0;
      out_len_q          <= cmd_i.emit_head ? len_q : '0;
      out_byte_q         <= cmd_i.emit_byte ? rdata_q : '0;
      last_q             <= cmd_i.emit_ack ||
                            (cmd_i.emit_head && (len_q == '0)) ||
                            (cmd_i.emit_byte && (rem_q == LEN_W'(1)));
      rep_pending_q      <= REPORT_W'(pending_q);
      rep_peak_pending_q <= REPORT_W'(peak_pending_q);
      rep_fill_q         <= REPORT_W'(held_q);
      rep_peak_fill_q    <= REPORT_W'(peak_held_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign kind_o           = kind_q;
  assign out_message_id_o = out_id_q;
  assign out_data_len_o   = out_len_q;
  assign out_byte_o       = out_byte_q;
  assign last_o           = last_q;
  assign pending_count_o  = rep_pending_q;
  assign peak_pending_o   = rep_peak_pending_q;
  assign fill_bytes_o     = rep_fill_q;
  assign peak_fill_o      = rep_peak_fill_q;

endmodule

@@ src/framed_byte_ring_message_queue_unit.sv @@
// Top level of the framed byte ring message queue.
//
// Usage: requests arrive on in_i and results leave on out_o, both valid/ready channels.
// A send header item checks the size limit and the free room, then writes the identifier
// and the two length bytes into the ring; payload bytes follow, one per send byte item,
// and the last one commits the message. A receive item pops the oldest committed message
// as a header result followed by one result per payload byte; the final result has last.
// Every other item yields a single acknowledge result carrying its status.
// Timing: the block works on one item at a time; in_i.ready is high only when idle.
// A send header item presents its acknowledge once the header is in the ring (one ring
// write per header byte over the single write port); a send byte item or a rejected item
// presents it from the acknowledge state; the next item is taken once it has been loaded.
// A receive item presents its header result once the header has been read, one ring
// read per header byte through the registered read port, then one payload result per cycle.
// Reset clears the pointers, counts and peaks; the ring contents are left as they are.
// When the receiver stalls, the result register holds its item and the run pauses; the
// next item is taken only after the final result of the current one has been loaded.
module framed_byte_ring_message_queue_unit (
  input logic          clk_i,
  input logic          rst_ni,
  fbrmq_in_if.sink     in_i,
  fbrmq_out_if.source  out_o
);
  import fbrmq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fbrmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbrmq_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (in_i.action),
    .message_id_i     (in_i.message_id),
    .data_len_i       (in_i.data_len),
    .data_byte_i      (in_i.data_byte),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .status_o         (out_o.status),
    .kind_o           (out_o.kind),
    .out_message_id_o (out_o.out_message_id),
    .out_data_len_o   (out_o.out_data_len),
    .out_byte_o       (out_o.out_byte),
    .last_o           (out_o.last),
    .pending_count_o  (out_o.pending_count),
    .peak_pending_o   (out_o.peak_pending),
    .fill_bytes_o     (out_o.fill_bytes),
    .peak_fill_o      (out_o.peak_fill)
  );

endmodule

@@ src/fbrmq_chk.sv @@
// Port-level checker for the message queue, bound to the top level.
module fbrmq_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [fbrmq_pkg::STATUS_W-1:0]  status_i,
  input logic [fbrmq_pkg::KIND_W-1:0]    kind_i,
  input logic [fbrmq_pkg::ID_W-1:0]      out_message_id_i,
  input logic [fbrmq_pkg::BYTE_W-1:0]    out_byte_i,
  input logic                            last_i,
  input logic [fbrmq_pkg::REPORT_W-1:0]  pending_count_i,
  input logic [fbrmq_pkg::REPORT_W-1:0]  peak_pending_i,
  input logic [fbrmq_pkg::REPORT_W-1:0]  fill_bytes_i,
  input logic [fbrmq_pkg::REPORT_W-1:0]  peak_fill_i
);
  import fbrmq_pkg::*;

  // A stalled result holds its item.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(kind_i) &&
      $stable(out_byte_i) && $stable(last_i))
    else $error("result item changed while stalled");

  // One item at a time: the request side closes right after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while an item is in progress");

  // High-water marks never fall below the current counts.
  a_peaks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (peak_fill_i >= fill_bytes_i) && (peak_pending_i >= pending_count_i))
    else $error("peak below current count");

  // An acknowledge is always the only result of its item.
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_ACK) |-> last_i)
    else $error("acknowledge without last");

  // Payload results are successful and carry no identifier.
  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_BYTE) |-> (status_i == ST_OK) && (out_message_id_i == '0))
    else $error("payload result with bad status or identifier");

endmodule

bind framed_byte_ring_message_queue_unit fbrmq_chk u_fbrmq_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .kind_i           (out_o.kind),
  .out_message_id_i (out_o.out_message_id),
  .out_byte_i       (out_o.out_byte),
  .last_i           (out_o.last),
  .pending_count_i  (out_o.pending_count),
  .peak_pending_i   (out_o.peak_pending),
  .fill_bytes_i     (out_o.fill_bytes),
  .peak_fill_i      (out_o.peak_fill)
);

@@ tb/tb.sv @@
// Self-checking testbench for the framed byte ring message queue.
`timescale 1ns / 100ps

module tb;
  import fbrmq_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_PRINTS    = 40;

  // Action code that the block does not define; it must be ignored.
  localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;

  // One result item as seen on the output channel.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     msg_id;
    logic [LEN_W-1:0]    msg_len;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [REPORT_W-1:0] pending;
    logic [REPORT_W-1:0] peak_pending;
    logic [REPORT_W-1:0] fill;
    logic [REPORT_W-1:0] peak_fill;
  } result_t;

  // Mirror of the queue state plus the results still owed by the block.
  class frame_ring_scoreboard;
    logic [BYTE_W-1:0] ring [QUEUE_BYTES];
    int      wr_ptr;
    int      rd_ptr;
    int      msgs;
    int      msgs_peak;
    int      held;
    int      held_peak;
    int      owed;
    int      open_size;
    int      results_seen;
    int      errors;
    result_t owed_results[$];

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr       = 0;
      rd_ptr       = 0;
      msgs         = 0;
      msgs_peak    = 0;
      held         = 0;
      held_peak    = 0;
      owed         = 0;
      open_size    = 0;
      results_seen = 0;
      errors       = 0;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    function void report(string msg);
      if (errors < MAX_PRINTS) $display("tb: mismatch: %s", msg);
      errors++;
    endfunction

    function void push_byte(logic [BYTE_W-1:0] b);
      ring[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % QUEUE_BYTES;
    endfunction

    function logic [BYTE_W-1:0] pop_byte();
      logic [BYTE_W-1:0] b;
      b = ring[rd_ptr];
      rd_ptr = (rd_ptr + 1) % QUEUE_BYTES;
      return b;
    endfunction

    // The last payload byte (or a zero-length header) makes the message visible.
    function void commit_message();
      held += open_size;
      if (held > held_peak) held_peak = held;
      msgs++;
      if (msgs > msgs_peak) msgs_peak = msgs;
      open_size = 0;
      owed      = 0;
    endfunction

    function result_t ack_of(logic [STATUS_W-1:0] st);
      result_t r;
      r.status       = st;
      r.kind         = KIND_ACK;
      r.msg_id       = '0;
      r.msg_len      = '0;
      r.data         = '0;
      r.last         = 1'b1;
      r.pending      = '0;
      r.peak_pending = '0;
      r.fill         = '0;
      r.peak_fill    = '0;
      return r;
    endfunction

    // Works out every result that one accepted request causes.
    function void note_request(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                               logic [LEN_W-1:0] len, logic [BYTE_W-1:0] data);
      result_t         run[$];
      result_t         r;
      int              size;
      int              plen;
      int              avail;
      int              i;
      logic [ID_W-1:0] rid;
      case (act)
        ACT_SEND_HDR: begin
          size = HDR_BYTES + int'(len);
          if (owed != 0) begin
            run.push_back(ack_of(ST_IGNORED));
          end else if (size > MAX_MESSAGE_BYTES) begin
            run.push_back(ack_of(ST_TOO_LARGE));
          end else if (QUEUE_BYTES - held < size) begin
            run.push_back(ack_of(ST_NO_ROOM));
          end else begin
            for (i = 0; i < ID_BYTES; i++) push_byte(id[8*i +: 8]);
            push_byte(BYTE_W'(len));
            push_byte('0);
            open_size = size;
            owed      = int'(len);
            if (len == 0) commit_message();
            run.push_back(ack_of(ST_OK));
          end
        end
        ACT_SEND_BYTE: begin
          if (owed == 0) begin
            run.push_back(ack_of(ST_IGNORED));
          end else begin
            push_byte(data);
            owed--;
            if (owed == 0) commit_message();
            run.push_back(ack_of(ST_OK));
          end
        end
        ACT_RECEIVE: begin
          if (msgs == 0) begin
            run.push_back(ack_of(ST_EMPTY));
          end else begin
            rid = '0;
            for (i = 0; i < ID_BYTES; i++) rid |= ID_W'(pop_byte()) << (8 * i);
            plen = int'(pop_byte());
            plen |= int'(pop_byte()) << 8;
            // Clamp the stored length to what the ring and the size limit allow.
            avail = (held > HDR_BYTES) ? held - HDR_BYTES : 0;
            if (plen > avail) plen = avail;
            if (plen > MAX_PAYLOAD) plen = MAX_PAYLOAD;
            r         = ack_of(ST_OK);
            r.kind    = KIND_HEADER;
            r.msg_id  = rid;
            r.msg_len = LEN_W'(plen);
            r.last    = (plen == 0);
            run.push_back(r);
            for (i = 0; i < plen; i++) begin
              r      = ack_of(ST_OK);
              r.kind = KIND_BYTE;
              r.data = pop_byte();
              r.last = (i + 1 == plen);
              run.push_back(r);
            end
            if (held > HDR_BYTES + plen) held -= HDR_BYTES + plen;
            else held = 0;
            msgs--;
          end
        end
        default: begin
          run.push_back(ack_of(ST_IGNORED));
        end
      endcase
      // Counts are the values after the whole request, on every result of the run.
      foreach (run[k]) begin
        run[k].pending      = REPORT_W'(msgs);
        run[k].peak_pending = REPORT_W'(msgs_peak);
        run[k].fill         = REPORT_W'(held);
        run[k].peak_fill    = REPORT_W'(held_peak);
        owed_results.push_back(run[k]);
      end
    endfunction

    function void compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                         results_seen, name, got, want));
    endfunction

    // Compares one accepted result with the oldest one owed.
    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result %0d of kind %0d arrived with nothing owed",
                         results_seen, got.kind));
      end else begin
        want = owed_results.pop_front();
        compare_field("status",        32'(got.status),       32'(want.status));
        compare_field("kind",          32'(got.kind),         32'(want.kind));
        compare_field("message id",    got.msg_id,            want.msg_id);
        compare_field("data length",   32'(got.msg_len),      32'(want.msg_len));
        compare_field("byte",          32'(got.data),         32'(want.data));
        compare_field("last",          32'(got.last),         32'(want.last));
        compare_field("pending count", 32'(got.pending),      32'(want.pending));
        compare_field("peak pending",  32'(got.peak_pending), 32'(want.peak_pending));
        compare_field("fill bytes",    32'(got.fill),         32'(want.fill));
        compare_field("peak fill",     32'(got.peak_fill),    32'(want.peak_fill));
      end
      results_seen++;
    endfunction

    function void check_leftover();
      if (owed_results.size() != 0)
        report($sformatf("%0d results never arrived", owed_results.size()));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   items_sent;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_left;

  frame_ring_scoreboard sb;

  fbrmq_in_if  in_if();
  fbrmq_out_if out_if();

  framed_byte_ring_message_queue_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Runaway guard.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.status       = out_if.status;
      got.kind         = out_if.kind;
      got.msg_id       = out_if.out_message_id;
      got.msg_len      = out_if.out_data_len;
      got.data         = out_if.out_byte;
      got.last         = out_if.last;
      got.pending      = out_if.pending_count;
      got.peak_pending = out_if.peak_pending;
      got.fill         = out_if.fill_bytes;
      got.peak_fill    = out_if.peak_fill;
      sb.check_result(got);
    end
  end

  // Offers one request and returns at the falling edge after it is taken.
  task automatic put_item(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                          logic [LEN_W-1:0] len, logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.message_id <= id;
    in_if.data_len   <= len;
    in_if.data_byte  <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_request(act, id, len, data);
    items_sent++;
    @(negedge clk);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.owed_results.size() != 0) @(negedge clk);
  endtask

  // Header followed by its payload; with breaks allowed, a receive may cut in or
  // the sequence may stop short and leave the message open.
  task automatic send_message(logic [ID_W-1:0] id, int len, bit breaks_ok);
    int i;
    put_item(ACT_SEND_HDR, id, LEN_W'(len), BYTE_W'($urandom));
    if (len <= MAX_PAYLOAD) begin
      for (i = 0; i < len; i++) begin
        if (breaks_ok && $urandom_range(99) < 3) break;
        if (breaks_ok && $urandom_range(99) < 4)
          put_item(ACT_RECEIVE, $urandom, LEN_W'($urandom), BYTE_W'($urandom));
        put_item(ACT_SEND_BYTE, $urandom, LEN_W'($urandom), BYTE_W'($urandom));
      end
    end
  endtask

  // Mostly well-formed messages and receives, with some noise.
  task automatic random_phase(int quota);
    int start;
    int pick;
    int len;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        case ($urandom_range(19))
          0:       len = $urandom_range(63, MAX_PAYLOAD + 1);
          1:       len = $urandom_range(MAX_PAYLOAD, 30);
          default: len = $urandom_range(8, 0);
        endcase
        send_message($urandom, len, 1'b1);
      end else if (pick < 85) begin
        put_item(ACT_RECEIVE, $urandom, LEN_W'($urandom), BYTE_W'($urandom));
      end else begin
        put_item(ACTION_W'($urandom_range(3, 0)), $urandom, LEN_W'($urandom),
                 BYTE_W'($urandom));
      end
    end
  endtask

  // Main sequence.
  initial begin
    int m;
    in_if.valid      = 1'b0;
    in_if.action     = '0;
    in_if.message_id = '0;
    in_if.data_len   = '0;
    in_if.data_byte  = '0;
    rst_n            = 1'b0;
    items_sent       = 0;
    stall_left       = 0;
    send_idle_pct    = 19;
    recv_idle_pct    = 82;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corner cases.
    put_item(ACT_RECEIVE, $urandom, LEN_W'($urandom), BYTE_W'($urandom));    // empty queue
    put_item(ACT_SEND_BYTE, $urandom, LEN_W'($urandom), 8'hFF);              // no open message
    put_item(ACT_UNDEFINED, $urandom, LEN_W'($urandom), BYTE_W'($urandom));  // undefined action
    put_item(ACT_SEND_HDR, 32'h0000_0000, 6'd0, BYTE_W'($urandom));  // zero length commits
    put_item(ACT_SEND_HDR, 32'hFFFF_FFFF, 6'd3, BYTE_W'($urandom));
    put_item(ACT_SEND_HDR, 32'h1234_5678, 6'd2, BYTE_W'($urandom));  // header while open
    put_item(ACT_RECEIVE, $urandom, LEN_W'($urandom), BYTE_W'($urandom));    // receive while open
    put_item(ACT_SEND_BYTE, $urandom, LEN_W'($urandom), 8'h00);
    put_item(ACT_SEND_BYTE, $urandom, LEN_W'($urandom), 8'hFF);
    put_item(ACT_SEND_BYTE, $urandom, LEN_W'($urandom), 8'h5A);
    put_item(ACT_SEND_HDR, $urandom, LEN_W'(MAX_PAYLOAD + 1), BYTE_W'($urandom));  // too large
    put_item(ACT_SEND_HDR, $urandom, 6'h3F, BYTE_W'($urandom));                    // largest field
    put_item(ACT_RECEIVE, $urandom, LEN_W'($urandom), BYTE_W'($urandom));
    put_item(ACT_RECEIVE, $urandom, LEN_W'($urandom), BYTE_W'($urandom));
    put_item(ACT_SEND_HDR, 32'hA5C3_0F96, 6'd1, BYTE_W'($urandom));
    put_item(ACT_SEND_BYTE, $urandom, LEN_W'($urandom), 8'h81);
    put_item(ACT_RECEIVE, $urandom, LEN_W'($urandom), BYTE_W'($urandom));

    // Random traffic under three idling mixes.
    random_phase(40);
    wait_for_results();
    send_idle_pct = 82;
    recv_idle_pct = 19;
    random_phase(40);
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // Long result hold-off while requests keep coming, so the block backs up.
    stall_left = HOLD_CYCLES;
    send_message($urandom, 20, 1'b0);
    for (m = 0; m < 3; m++)
      put_item(ACT_RECEIVE, $urandom, LEN_W'($urandom), BYTE_W'($urandom));
    random_phase(15);
    wait_for_results();
    random_phase(15);

    // Drain and settle.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
